// File: sv/sv39_page_table_map_unmap_unit_assert.svh
// assertion macros for the sv39 page table unit
`ifndef SV39_PAGE_TABLE_MAP_UNMAP_UNIT_ASSERT_SVH
`define SV39_PAGE_TABLE_MAP_UNMAP_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define SV39PT_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("sv39pt assertion failed");
`define SV39PT_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("sv39pt assertion failed");
`else
`define SV39PT_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define SV39PT_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

// File: sv/sv39pt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sv39pt_pkg;

    localparam int TABLE_PAGES_DEF = 16;
    localparam int LEVEL_BITS      = 9;
    localparam int TABLE_ENTRIES   = 512;
    localparam int VPN_W           = 27;
    localparam int PPN_W           = 44;
    localparam int ENTRY_W         = 48;
    localparam int FLAG_W          = 4;

    localparam logic [FLAG_W-1:0] PTE_PTR  = 4'b0001;
    localparam logic [FLAG_W-1:0] PTE_LEAF = 4'b1111;

    typedef enum logic [1:0] {
        SIZE_4K = 2'd0,
        SIZE_2M = 2'd1,
        SIZE_1G = 2'd2,
        SIZE_BAD = 2'd3
    } page_size_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_MISALIGNED = 3'd1,
        ST_MAPPED     = 3'd2,
        ST_NOT_MAPPED = 3'd3,
        ST_WRONG_SIZE = 3'd4,
        ST_NO_SPACE   = 3'd5
    } status_t;

    function automatic logic [LEVEL_BITS-1:0] level_index(
        input logic [VPN_W-1:0] vpn,
        input logic [1:0]       level
    );
        logic [LEVEL_BITS-1:0] idx;
        unique case (level)
            2'd0:    idx = vpn[8:0];
            2'd1:    idx = vpn[17:9];
            2'd2:    idx = vpn[26:18];
            default: idx = vpn[8:0];
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

// File: sv/sv39_page_table_map_unmap_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Sv39 page table map/unmap engine. Each request word maps or unmaps one 4 KiB,
// 2 MiB or 1 GiB page and returns one status word. The three-level table lives in an
// internal single-port-read, single-port-write store of TABLE_PAGES*512 entries; table
// page zero is the root and new tables come from a bump counter and are never freed.
// After reset the store is swept to zero one entry per cycle, over all its entries,
// with s_tready low. A request then accepts and starts the root read, reads back each
// table level from the store down to the level set by the page size, or until the walk
// ends early (the level's update is written in the same cycle), and moves the status
// into the output register; requests rejected for size or alignment skip the reads. A
// new request is taken while the previous status still waits on m_tready.
module sv39_page_table_map_unmap_unit #(
    parameter int TABLE_PAGES = sv39pt_pkg::TABLE_PAGES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,  // virt_page[26:0], phys_page[70:27], page_size[72:71]
    input  wire logic [0:0]  s_tuser,  // opcode[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata   // status[2:0]
);

    localparam int DEPTH  = TABLE_PAGES * sv39pt_pkg::TABLE_ENTRIES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PAGE_W = $clog2(TABLE_PAGES);
    localparam int NF_W   = $clog2(TABLE_PAGES + 1);
    localparam int EW     = sv39pt_pkg::ENTRY_W;
    localparam int FW     = sv39pt_pkg::FLAG_W;
    localparam int PW     = sv39pt_pkg::PPN_W;
    localparam int VW     = sv39pt_pkg::VPN_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DONE
    } state_t;

    state_t                      state_reg, state_next;
    logic [ADDR_W-1:0]           clr_reg, clr_next;
    logic [NF_W-1:0]             nf_reg, nf_next;
    logic                        unmap_reg, unmap_next;
    logic [VW-1:0]               vpn_reg, vpn_next;
    logic [PW-1:0]               ppn_reg, ppn_next;
    logic [1:0]                  size_reg, size_next;
    logic [1:0]                  level_reg, level_next;
    logic [PAGE_W-1:0]           page_reg, page_next;
    sv39pt_pkg::status_t         result_reg, result_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    sv39pt_pkg::status_t         m_status_reg, m_status_next;

    logic                        ram_wr_en;
    logic [ADDR_W-1:0]           ram_wr_addr;
    logic [EW-1:0]               ram_wr_data;
    logic                        ram_rd_en;
    logic [ADDR_W-1:0]           ram_rd_addr;
    logic [EW-1:0]               ram_rd_data;

    logic                        in_unmap;
    logic [VW-1:0]               in_vpn;
    logic [PW-1:0]               in_ppn;
    logic [1:0]                  in_size;
    logic                        misaligned;
    logic                        e_valid;
    logic                        e_leaf;
    logic [PW-1:0]               e_ppn;
    logic [ADDR_W-1:0]           slot;
    logic [1:0]                  level_dn;

    assign in_vpn   = s_tdata[26:0];
    assign in_ppn   = s_tdata[70:27];
    assign in_size  = s_tdata[72:71];
    assign in_unmap = s_tuser[0];

    assign misaligned =
        ((in_size == sv39pt_pkg::SIZE_2M) &&
         ((in_vpn[8:0] != '0) || (!in_unmap && (in_ppn[8:0] != '0)))) ||
        ((in_size == sv39pt_pkg::SIZE_1G) &&
         ((in_vpn[17:0] != '0) || (!in_unmap && (in_ppn[17:0] != '0))));

    assign e_valid  = ram_rd_data[0];
    assign e_leaf   = (ram_rd_data[FW-1:1] != '0);
    assign e_ppn    = ram_rd_data[EW-1:FW];
    assign slot     = {page_reg, sv39pt_pkg::level_index(vpn_reg, level_reg)};
    assign level_dn = level_reg - 2'd1;

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        nf_next       = nf_reg;
        unmap_next    = unmap_reg;
        vpn_next      = vpn_reg;
        ppn_next      = ppn_reg;
        size_next     = size_reg;
        level_next    = level_reg;
        page_next     = page_reg;
        result_next   = result_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_status_next = m_status_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = slot;
        ram_wr_data   = '0;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = slot;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg;
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    unmap_next = in_unmap;
                    vpn_next   = in_vpn;
                    ppn_next   = in_ppn;
                    size_next  = in_size;
                    level_next = 2'd2;
                    page_next  = '0;
                    if (in_size == sv39pt_pkg::SIZE_BAD)
                    begin
                        result_next = sv39pt_pkg::ST_WRONG_SIZE;
                        state_next  = S_DONE;
                    end
                    else if (misaligned)
                    begin
                        result_next = sv39pt_pkg::ST_MISALIGNED;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = {PAGE_W'(0), sv39pt_pkg::level_index(in_vpn, 2'd2)};
                        state_next  = S_READ;
                    end
                end
            end
            S_READ:
            begin
                if (level_reg != size_reg)
                begin
                    priority if (!e_valid)
                    begin
                        if (unmap_reg)
                        begin
                            result_next = sv39pt_pkg::ST_NOT_MAPPED;
                            state_next  = S_DONE;
                        end
                        else if (nf_reg == NF_W'(TABLE_PAGES))
                        begin
                            result_next = sv39pt_pkg::ST_NO_SPACE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_data = {(EW - FW)'(nf_reg), sv39pt_pkg::PTE_PTR};
                            nf_next     = nf_reg + 1'b1;
                            page_next   = nf_reg[PAGE_W-1:0];
                            level_next  = level_dn;
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = {nf_reg[PAGE_W-1:0],
                                           sv39pt_pkg::level_index(vpn_reg, level_dn)};
                        end
                    end
                    else if (e_leaf || (e_ppn >= PW'(TABLE_PAGES)))
                    begin
                        result_next = unmap_reg ? sv39pt_pkg::ST_WRONG_SIZE
                                                : sv39pt_pkg::ST_MAPPED;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        page_next   = e_ppn[PAGE_W-1:0];
                        level_next  = level_dn;
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = {e_ppn[PAGE_W-1:0],
                                       sv39pt_pkg::level_index(vpn_reg, level_dn)};
                    end
                end
                else
                begin
                    state_next = S_DONE;
                    if (unmap_reg)
                    begin
                        if (!e_valid)
                        begin
                            result_next = sv39pt_pkg::ST_NOT_MAPPED;
                        end
                        else
                        begin
                            ram_wr_en   = 1'b1;
                            result_next = sv39pt_pkg::ST_OK;
                        end
                    end
                    else
                    begin
                        if (e_valid)
                        begin
                            result_next = sv39pt_pkg::ST_MAPPED;
                        end
                        else
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_data = {ppn_reg, sv39pt_pkg::PTE_LEAF};
                            result_next = sv39pt_pkg::ST_OK;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_status_next = result_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            nf_reg       <= NF_W'(1);
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            nf_reg       <= nf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unmap_reg    <= unmap_next;
        vpn_reg      <= vpn_next;
        ppn_reg      <= ppn_next;
        size_reg     <= size_next;
        level_reg    <= level_next;
        page_reg     <= page_next;
        result_reg   <= result_next;
        m_status_reg <= m_status_next;
    end

    sv39pt_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, m_status_reg};

`include "sv39_page_table_map_unmap_unit_assert.svh"

    `SV39PT_ASSERT_SAME(a_nf_range, clk, rst_n, 1'b1, (nf_reg != '0) && (nf_reg <= NF_W'(TABLE_PAGES)))
    `SV39PT_ASSERT_NEXT(a_nf_step, clk, rst_n, 1'b1, (nf_reg == $past(nf_reg)) || (nf_reg == NF_W'($past(nf_reg) + 1'b1)))
    `SV39PT_ASSERT_SAME(a_wr_state, clk, rst_n, ram_wr_en, (state_reg == S_CLEAR) || (state_reg == S_READ))
    `SV39PT_ASSERT_SAME(a_level_floor, clk, rst_n, state_reg == S_READ, level_reg >= size_reg)

endmodule

`default_nettype wire

// File: sv/sv39pt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sv39pt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
